[rtl/core/pse_pkg.sv]
// ----------------------------------------------------------------------------
// Postfix evaluator package
// Shared constants, codes and types of the postfix stack evaluator.
// ----------------------------------------------------------------------------
package pse_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 32;

  // ASCII codes of the accepted characters.
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_ADD  = 8'h2B;
  localparam logic [7:0] CH_SUB  = 8'h2D;
  localparam logic [7:0] CH_MUL  = 8'h2A;
  localparam logic [7:0] CH_DIV  = 8'h2F;
  localparam logic [7:0] CH_POW  = 8'h24;

  typedef enum logic [2:0] {
    ST_OK, ST_UNDER, ST_OVER, ST_DIVZ, ST_UNKNOWN
  } status_t;

  typedef enum logic [2:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_POW
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef enum logic [2:0] {
    A_IDLE, A_MUL, A_DIV, A_POW, A_DONE
  } alu_state_t;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_RD_A, S_LATCH_A, S_CALC, S_REPORT, S_TOP, S_DONE
  } seq_state_t;

endpackage

[rtl/core/pse_stack_ram.sv]
// ----------------------------------------------------------------------------
// Stack memory
// Single-port-write, single-port-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module pse_stack_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/pse_alu.sv]
// ----------------------------------------------------------------------------
// Multi-cycle arithmetic unit
// Add, subtract, multiply, restoring divide and square-and-multiply power
// on one shared 32-bit multiplier.
// ----------------------------------------------------------------------------
module pse_alu (
  input  logic              clk,
  input  logic              rst_n,
  input  pse_pkg::alu_req_t req,
  input  logic [31:0]       a,
  input  logic [31:0]       b,
  output logic              done,
  output logic [31:0]       result
);
  import pse_pkg::*;

  alu_state_t  state_r, state_nxt;
  logic [31:0] x_r, y_r, r_r, quo_r, rem_r;
  logic        neg_r, phase_r;
  logic [4:0]  cnt_r;
  logic [31:0] mul_a, mul_b, prod, quo_nxt;
  logic [32:0] trial;

  always_comb begin
    if (state_r == A_POW) begin
      mul_a = phase_r ? x_r : r_r;
    end else begin
      mul_a = x_r;
    end
    mul_b = (state_r == A_POW) ? x_r : y_r;
    prod  = mul_a * mul_b;
    trial = {rem_r, quo_r[31]} - {1'b0, y_r};
    quo_nxt = {quo_r[30:0], ~trial[32]};
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      A_IDLE: begin
        if (req.start) begin
          case (req.op)
            OP_MUL:  state_nxt = A_MUL;
            OP_DIV:  state_nxt = A_DIV;
            OP_POW:  state_nxt = b[31] ? A_DONE : A_POW;
            default: state_nxt = A_DONE;
          endcase
        end
      end
      A_MUL:  state_nxt = A_DONE;
      A_DIV:  if (cnt_r == 5'd31) state_nxt = A_DONE;
      A_POW:  if (phase_r && cnt_r == 5'd30) state_nxt = A_DONE;
      A_DONE: state_nxt = A_IDLE;
      default: state_nxt = A_IDLE;
    endcase
  end

  always_comb begin
    done   = (state_r == A_DONE);
    result = r_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      A_IDLE: begin
        if (req.start) begin
          x_r     <= a;
          cnt_r   <= 5'd0;
          phase_r <= 1'b0;
          case (req.op)
            OP_ADD: begin
              y_r <= b;
              r_r <= a + b;
            end
            OP_SUB: begin
              y_r <= b;
              r_r <= a - b;
            end
            OP_MUL: y_r <= b;
            OP_DIV: begin
              quo_r <= a[31] ? (32'd0 - a) : a;
              y_r   <= b[31] ? (32'd0 - b) : b;
              rem_r <= 32'd0;
              neg_r <= a[31] ^ b[31];
            end
            OP_POW: begin
              y_r <= b;
              // Negative exponent: only a base of plus or minus one survives.
              if (b[31]) begin
                if (a == 32'd1) begin
                  r_r <= 32'd1;
                end else if (a == 32'hFFFF_FFFF) begin
                  r_r <= b[0] ? 32'hFFFF_FFFF : 32'd1;
                end else begin
                  r_r <= 32'd0;
                end
              end else begin
                r_r <= 32'd1;
              end
            end
            default: begin
              y_r <= b;
              r_r <= 32'd0;
            end
          endcase
        end
      end
      A_MUL: r_r <= prod;
      A_DIV: begin
        rem_r <= trial[32] ? {rem_r[30:0], quo_r[31]} : trial[31:0];
        quo_r <= quo_nxt;
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          r_r <= neg_r ? (32'd0 - quo_nxt) : quo_nxt;
        end
      end
      A_POW: begin
        if (!phase_r) begin
          if (y_r[0]) begin
            r_r <= prod;
          end
          phase_r <= 1'b1;
        end else begin
          x_r     <= prod;
          y_r     <= {1'b0, y_r[31:1]};
          phase_r <= 1'b0;
          cnt_r   <= cnt_r + 5'd1;
        end
      end
      default: ;
    endcase
  end

endmodule

[rtl/core/postfix_stack_evaluator.sv]
// ----------------------------------------------------------------------------
// Postfix stack evaluator
// Evaluates a postfix expression fed one character per transaction.
// ----------------------------------------------------------------------------
// Sequence, from the accepting cycle to the load of the result register: the
// character is decoded; a digit is pushed, while an operator reads its right
// and then its left operand and, unless it divides by zero, runs the shared
// unit (a power in 31 rounds of a multiply and a square) and writes back; the
// top is then read unless the stack is empty; the load waits on the channel.
// Throughput: one character at a time; the next is taken once the previous
// result sits in the output register.
// Reset: synchronous, active low; empties the stack (count to zero).
// ----------------------------------------------------------------------------
module postfix_stack_evaluator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] symbol
  input  logic        in_tlast,   // last_symbol
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] top_value, [36:32] depth, [39:37] status
  output logic        out_tlast   // expression_end
);
  import pse_pkg::*;

  seq_state_t         state_r, state_nxt;
  logic [7:0]         sym_r;
  logic               last_r;
  logic [CNT_W-1:0]   count_r;
  status_t            status_r;
  logic [DATA_W-1:0]  b_r, top_r;
  logic [39:0]        out_tdata_r;
  logic               out_tlast_r, out_tvalid_r;

  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [DATA_W-1:0]  ram_wdata, ram_rdata;
  alu_req_t           alu_req;
  logic               alu_done;
  logic [DATA_W-1:0]  alu_result;

  logic               is_digit, is_op, stack_full, out_free;
  alu_op_t            sym_op;

  // Character classification of the held symbol.
  always_comb begin
    is_digit = (sym_r >= CH_ZERO) && (sym_r <= CH_NINE);
    is_op    = (sym_r == CH_ADD) || (sym_r == CH_SUB) || (sym_r == CH_MUL) ||
               (sym_r == CH_DIV) || (sym_r == CH_POW);
    case (sym_r)
      CH_ADD:  sym_op = OP_ADD;
      CH_SUB:  sym_op = OP_SUB;
      CH_MUL:  sym_op = OP_MUL;
      CH_DIV:  sym_op = OP_DIV;
      default: sym_op = OP_POW;
    endcase
    stack_full = (count_r == CNT_W'(STACK_DEPTH));
    out_free   = !out_tvalid_r || out_tready;
  end

  pse_stack_ram #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The left operand arrives straight from the memory read port.
  pse_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (alu_req),
    .a      (ram_rdata),
    .b      (b_r),
    .done   (alu_done),
    .result (alu_result)
  );

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    if (in_tvalid) state_nxt = S_DECODE;
      S_DECODE:  state_nxt = (is_op && count_r >= CNT_W'(2)) ? S_RD_A : S_REPORT;
      S_RD_A:    state_nxt = S_LATCH_A;
      S_LATCH_A: begin
        if (sym_op == OP_DIV && b_r == '0) begin
          state_nxt = S_REPORT;
        end else begin
          state_nxt = S_CALC;
        end
      end
      S_CALC:    if (alu_done) state_nxt = S_REPORT;
      S_REPORT:  state_nxt = (count_r != '0) ? S_TOP : S_DONE;
      S_TOP:     state_nxt = S_DONE;
      S_DONE:    if (out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs: memory strobes and the unit request.
  always_comb begin
    ram_we        = 1'b0;
    ram_waddr     = ADDR_W'(count_r);
    ram_wdata     = DATA_W'(sym_r - CH_ZERO);
    ram_re        = 1'b0;
    ram_raddr     = ADDR_W'(count_r - CNT_W'(1));
    alu_req.start = 1'b0;
    alu_req.op    = sym_op;
    in_tready     = 1'b0;
    case (state_r)
      S_IDLE:   in_tready = 1'b1;
      S_DECODE: begin
        if (is_digit && !stack_full) begin
          ram_we = 1'b1;
        end else if (is_op && count_r >= CNT_W'(2)) begin
          // Right operand is the top entry.
          ram_re = 1'b1;
        end
      end
      S_RD_A: begin
        ram_re    = 1'b1;
        ram_raddr = ADDR_W'(count_r - CNT_W'(2));
      end
      S_LATCH_A: alu_req.start = !(sym_op == OP_DIV && b_r == '0);
      S_CALC: begin
        // Result replaces the left operand; the pop follows in the count.
        ram_we    = alu_done;
        ram_waddr = ADDR_W'(count_r - CNT_W'(2));
        ram_wdata = alu_result;
      end
      S_REPORT: begin
        // The final character reports the bottom entry instead of the top.
        ram_re = (count_r != '0);
        if (last_r) begin
          ram_raddr = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DONE && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            sym_r    <= in_tdata;
            last_r   <= in_tlast;
            status_r <= ST_OK;
          end
        end
        S_DECODE: begin
          if (is_digit) begin
            if (stack_full) begin
              status_r <= ST_OVER;
            end else begin
              count_r <= count_r + CNT_W'(1);
            end
          end else if (is_op) begin
            if (count_r < CNT_W'(2)) begin
              status_r <= ST_UNDER;
            end
          end else begin
            status_r <= ST_UNKNOWN;
          end
        end
        S_RD_A: b_r <= ram_rdata;
        S_LATCH_A: begin
          if (sym_op == OP_DIV && b_r == '0) begin
            status_r <= ST_DIVZ;
          end
        end
        S_CALC: begin
          if (alu_done) begin
            count_r <= count_r - CNT_W'(1);
          end
        end
        S_REPORT: top_r <= '0;
        S_TOP:    top_r <= ram_rdata;
        S_DONE: begin
          if (out_free) begin
            out_tlast_r  <= last_r;
            out_tdata_r  <= {status_r, (last_r ? 5'd0 : 5'(count_r)), top_r};
            if (last_r) begin
              count_r <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  // The stack count never runs past the memory depth.
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  // Memory writes happen only on a push or a unit writeback.
  assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_DECODE || state_r == S_CALC))
    else $error("stray stack write");

  // A new result is only ever loaded from the completion state.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == S_DONE))
    else $error("result loaded outside completion");

endmodule

[verif/tb_postfix_stack_evaluator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Postfix evaluator testbench
// Feeds postfix characters with random bursts and gaps, stalls the result
// channel on its own pattern, and compares every result transaction against
// a behavioral model of the evaluation stack kept inside this bench.
// ----------------------------------------------------------------------------
module tb_postfix_stack_evaluator;
  import pse_pkg::*;

  localparam int N_RANDOM   = 1600;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [31:0] value;
    logic [4:0]  depth;
    status_t     status;
    logic        expr_end;
  } eval_result_t;

  // One row of the directed table. When has_golden is set, the typed-in
  // result is checked against the model's own prediction as well.
  typedef struct packed {
    logic [7:0]   sym;
    logic         last;
    logic         has_golden;
    eval_result_t golden;
  } vector_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        out_tlast;

  // Model state: the stack and its fill level.
  logic [31:0] model_stack [STACK_DEPTH];
  int          model_count;

  eval_result_t result_queue[$];
  int  error_count;
  int  idle_cycles;
  bit  hold_off;

  postfix_stack_evaluator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Power by square-and-multiply over 31 rounds, wrapping at 32 bits.
  // A negative exponent yields zero except for bases of one and minus one.
  function automatic logic [31:0] power_wrap(logic [31:0] base, logic [31:0] ex);
    logic [31:0] acc;
    acc = 32'd1;
    if (ex[31]) begin
      if (base == 32'd1) return 32'd1;
      if (base == 32'hFFFF_FFFF) return ex[0] ? 32'hFFFF_FFFF : 32'd1;
      return 32'd0;
    end
    for (int k = 0; k < 31; k++) begin
      if (ex[0]) acc = acc * base;
      base = base * base;
      ex   = ex >> 1;
    end
    return acc;
  endfunction

  // Advances the model by one character and returns the expected result.
  function automatic eval_result_t evaluate_symbol(logic [7:0] sym, logic last);
    eval_result_t res;
    logic [31:0]  a, b, r;
    logic signed [31:0] sa, sb;
    bit           apply;
    res = '0;
    res.status = ST_OK;
    if (sym >= CH_ZERO && sym <= CH_NINE) begin
      if (model_count >= STACK_DEPTH) begin
        res.status = ST_OVER;
      end else begin
        model_stack[model_count] = {24'd0, sym - CH_ZERO};
        model_count++;
      end
    end else if (sym == CH_ADD || sym == CH_SUB || sym == CH_MUL ||
                 sym == CH_DIV || sym == CH_POW) begin
      if (model_count < 2) begin
        res.status = ST_UNDER;
      end else begin
        a = model_stack[model_count - 2];
        b = model_stack[model_count - 1];
        apply = 1'b1;
        r = '0;
        case (sym)
          CH_ADD: r = a + b;
          CH_SUB: r = a - b;
          CH_MUL: r = a * b;
          CH_DIV: begin
            if (b == 32'd0) begin
              apply = 1'b0;
              res.status = ST_DIVZ;
            end else if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) begin
              // Most negative over minus one wraps back to itself.
              r = 32'h8000_0000;
            end else begin
              sa = a;
              sb = b;
              r  = sa / sb;
            end
          end
          default: r = power_wrap(a, b);
        endcase
        if (apply) begin
          model_stack[model_count - 2] = r;
          model_count--;
        end
      end
    end else begin
      res.status = ST_UNKNOWN;
    end
    if (last) begin
      res.value   = (model_count > 0) ? model_stack[0] : 32'd0;
      model_count = 0;
    end else if (model_count > 0) begin
      res.value = model_stack[model_count - 1];
    end
    res.depth    = model_count[4:0];
    res.expr_end = last;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    error_count++;
  endtask

  // Drives one character and waits for its transaction, then pushes the
  // prediction. Called just after a falling edge.
  task automatic send_symbol(logic [7:0] sym, logic last);
    in_tvalid <= 1'b1;
    in_tdata  <= sym;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    result_queue.push_back(evaluate_symbol(sym, last));
    @(negedge clk);
  endtask

  task automatic pause_sender(int cycles);
    in_tvalid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Picks a character: mostly well-formed digits and operators, some noise.
  function automatic logic [7:0] pick_symbol();
    int roll;
    logic [7:0] ops [5];
    ops = '{CH_ADD, CH_SUB, CH_MUL, CH_DIV, CH_POW};
    roll = $urandom_range(99);
    if (roll < 45) return CH_ZERO + 8'($urandom_range(9));
    if (roll < 92) return ops[$urandom_range(4)];
    return 8'($urandom_range(255));
  endfunction

  // Result channel: stalls on its own pattern, with one long hold-off.
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) out_tready <= 1'b0;
      else case ($urandom_range(3))
        0:       out_tready <= ($urandom_range(3) == 0);
        default: out_tready <= 1'b1;
      endcase
    end
  end

  // Compare each result transaction with the oldest prediction.
  always @(posedge clk) begin
    eval_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (result_queue.size() == 0) begin
        report_mismatch("unexpected result", 64'(out_tdata), 64'd0);
      end else begin
        want = result_queue.pop_front();
        if (out_tdata[31:0] !== want.value)
          report_mismatch("top_value", 64'(out_tdata[31:0]), 64'(want.value));
        if (out_tdata[36:32] !== want.depth)
          report_mismatch("depth", 64'(out_tdata[36:32]), 64'(want.depth));
        if (out_tdata[39:37] !== want.status)
          report_mismatch("status", 64'(out_tdata[39:37]), 64'(want.status));
        if (out_tlast !== want.expr_end)
          report_mismatch("expression_end", 64'(out_tlast), 64'(want.expr_end));
      end
    end
  end

  // Watchdog: counts cycles with no transaction on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_postfix_stack_evaluator NOT OK");
      $finish;
    end
  end

  vector_t directed [20];

  initial begin
    int burst;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    error_count = 0;
    hold_off    = 1'b0;
    model_count = 0;
    for (int i = 0; i < STACK_DEPTH; i++) model_stack[i] = '0;

    // Golden rows hold the result as read straight off the stack rules.
    directed = '{
      '{CH_ADD,  1'b0, 1'b1, '{32'd0, 5'd0, ST_UNDER, 1'b0}},
      '{8'hFF,   1'b0, 1'b1, '{32'd0, 5'd0, ST_UNKNOWN, 1'b0}},
      '{8'h00,   1'b1, 1'b1, '{32'd0, 5'd0, ST_UNKNOWN, 1'b1}},
      '{CH_NINE, 1'b0, 1'b1, '{32'd9, 5'd1, ST_OK, 1'b0}},
      '{CH_ZERO, 1'b0, 1'b1, '{32'd0, 5'd2, ST_OK, 1'b0}},
      '{CH_DIV,  1'b0, 1'b1, '{32'd0, 5'd2, ST_DIVZ, 1'b0}},
      '{CH_SUB,  1'b0, 1'b1, '{32'd9, 5'd1, ST_OK, 1'b0}},
      '{CH_ZERO, 1'b0, 1'b0, '0},
      '{CH_ZERO, 1'b0, 1'b0, '0},
      '{CH_POW,  1'b0, 1'b0, '0},     // zero to the zero
      '{CH_MUL,  1'b0, 1'b0, '0},
      '{CH_ZERO, 1'b0, 1'b0, '0},
      '{CH_NINE, 1'b0, 1'b0, '0},
      '{CH_SUB,  1'b0, 1'b0, '0},     // minus nine
      '{CH_POW,  1'b0, 1'b0, '0},     // negative exponent
      '{CH_NINE, 1'b0, 1'b0, '0},
      '{CH_NINE, 1'b0, 1'b0, '0},
      '{CH_POW,  1'b0, 1'b0, '0},     // nine to the nine
      '{CH_ADD,  1'b0, 1'b0, '0},
      '{CH_NINE, 1'b1, 1'b0, '0}
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i]) begin
      send_symbol(directed[i].sym, directed[i].last);
      if (directed[i].has_golden &&
          result_queue[result_queue.size() - 1] !== directed[i].golden) begin
        report_mismatch("directed row", 64'(result_queue[result_queue.size() - 1]),
                        64'(directed[i].golden));
      end
    end
    pause_sender(2);

    // Fill past the top for overflow, with the receiver held off so the
    // block stalls its input; then most negative over minus one.
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < STACK_DEPTH + 2; i++) send_symbol(CH_NINE, 1'b0);
    join
    send_symbol(CH_NINE, 1'b1);
    // Two to the power 9 * 3 + 4 gives the most negative value.
    send_symbol(CH_ZERO + 8'd2, 1'b0);
    send_symbol(CH_ZERO + 8'd9, 1'b0);
    send_symbol(CH_ZERO + 8'd3, 1'b0);
    send_symbol(CH_MUL, 1'b0);
    send_symbol(CH_ZERO + 8'd4, 1'b0);
    send_symbol(CH_ADD, 1'b0);
    send_symbol(CH_POW, 1'b0);
    // Zero minus one gives the divisor of minus one.
    send_symbol(CH_ZERO, 1'b0);
    send_symbol(CH_ZERO + 8'd1, 1'b0);
    send_symbol(CH_SUB, 1'b0);
    send_symbol(CH_DIV, 1'b0);
    send_symbol(CH_ZERO, 1'b1);

    // Random part: bursts of characters with random gaps.
    for (int n = 0; n < N_RANDOM; ) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && n < N_RANDOM; k++, n++)
        send_symbol(pick_symbol(), ($urandom_range(19) == 0));
      if ($urandom_range(2) != 0) pause_sender($urandom_range(1, 12));
    end
    in_tvalid <= 1'b0;

    while (result_queue.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_postfix_stack_evaluator OK");
    end else begin
      $display("tb_postfix_stack_evaluator NOT OK");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/pse_pkg.sv
rtl/core/pse_stack_ram.sv
rtl/core/pse_alu.sv
rtl/core/postfix_stack_evaluator.sv
verif/tb_postfix_stack_evaluator.sv
